/* hw/rtl/idq_pkg.sv */
`timescale 1ns / 1ps
package idq_pkg;
    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int PTR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
    localparam int SUM_W     = CNT_W + 1;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [2:0] ACT_INSERT     = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_DELETE     = 3'd4;
    localparam logic [2:0] ACT_READ       = 3'd5;
    localparam logic [2:0] ACT_POP_REAR   = 3'd6;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] PC_BEFORE = 2'd0;
    localparam logic [1:0] PC_DEREF  = 2'd1;
    localparam logic [1:0] PC_PAST   = 2'd2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // physical slot of a logical index (index at most CAPACITY)
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [CNT_W-1:0] logical);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(logical);
        if (sum >= SUM_W'(CAPACITY)) sum = sum - SUM_W'(CAPACITY);
        return sum[PTR_W-1:0];
    endfunction
endpackage

/* hw/rtl/idq_store.sv */
`timescale 1ns / 1ps
module idq_store (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [idq_pkg::PTR_W-1:0]      i_waddr,
    input  logic [idq_pkg::WORD_BITS-1:0]  i_wdata,
    input  logic [idq_pkg::PTR_W-1:0]      i_raddr,
    output logic [idq_pkg::WORD_BITS-1:0]  o_rdata
);
    import idq_pkg::*;

    logic [WORD_BITS-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/indexed_deque_engine.sv */
`timescale 1ns / 1ps
// Push, pop and refusals finish in the execute state; a read adds a store read-out
// state; insert before p and delete at p shift the words from p to the rear, by a
// read-then-write of one word at a time through the store.
// One request at a time: busy stays high until o_done; a new request may start
// in the o_done cycle. Results are never stalled by the receiver.
// Reset (synchronous, active low) empties the deque; store contents undefined.
module indexed_deque_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic signed [7:0]  i_position,
    input  logic signed [31:0] i_value,
    output logic        o_done,
    output logic signed [31:0] o_read_value,
    output logic [6:0]  o_element_count,
    output logic [1:0]  o_status,
    output logic [1:0]  o_position_class
);
    import idq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RDOUT = 7'b0000100,
        S_INS   = 7'b0001000,
        S_INSWR = 7'b0010000,
        S_DEL   = 7'b0100000,
        S_DELWR = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // request latched at acceptance
    logic [2:0]  r_act;
    logic [7:0]  r_pos;
    logic [31:0] r_val;

    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;     // shift cursor (logical)
    logic [1:0]       r_pc, n_pc;

    logic             r_done, n_done;
    logic [31:0]      r_rd, n_rd;
    logic [1:0]       r_status, n_status;

    logic                 we;
    logic [PTR_W-1:0]     waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    // position against the count before the request
    logic             pos_neg;
    logic [CMP_W-1:0] pos_u, cnt_u;
    logic [CNT_W-1:0] pos_c;
    logic [1:0]       pclass;
    logic             full, empty;

    assign pos_neg = r_pos[7];
    assign pos_u   = CMP_W'(r_pos[6:0]);
    assign cnt_u   = CMP_W'(r_count);
    assign pos_c   = CNT_W'(pos_u);
    assign full    = (r_count == CAP_CNT);
    assign empty   = (r_count == '0);
    assign pclass  = pos_neg ? PC_BEFORE : ((pos_u < cnt_u) ? PC_DEREF : PC_PAST);

    idq_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pc     = r_pc;
        n_done   = 1'b0;
        n_rd     = '0;
        n_status = r_status;
        we       = 1'b0;
        waddr    = slot_of(r_front, r_idx);
        wdata    = WORD_BITS'(r_val);
        raddr    = slot_of(r_front, r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_pc     = pclass;
                n_status = ST_DONE;
                n_state  = S_IDLE;
                n_done   = 1'b1;
                unique case (r_act) inside
                    ACT_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_front = (r_front == '0) ? PTR_W'(CAPACITY - 1)
                                                      : r_front - 1'b1;
                            we      = 1'b1;
                            waddr   = n_front;
                            n_count = r_count + 1'b1;
                        end
                    end
                    ACT_PUSH_REAR: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = slot_of(r_front, r_count);
                            n_count = r_count + 1'b1;
                        end
                    end
                    ACT_INSERT: begin
                        if (pos_neg || pos_u > cnt_u) begin
                            n_status = ST_BAD_POS;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_done  = 1'b0;
                            n_idx   = r_count;
                            n_state = S_INS;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_REAR: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                            if (r_act == ACT_POP_FRONT)
                                n_front = slot_of(r_front, CNT_W'(1));
                        end
                    end
                    ACT_DELETE: begin
                        if (pclass != PC_DEREF) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_done  = 1'b0;
                            n_idx   = pos_c;
                            n_state = S_DEL;
                        end
                    end
                    ACT_READ: begin
                        if (pclass != PC_DEREF) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            raddr   = slot_of(r_front, pos_c);
                            n_done  = 1'b0;
                            n_state = S_RDOUT;
                        end
                    end
                    default: n_status = ST_BAD_POS;
                endcase
            end
            S_RDOUT: begin
                n_rd    = 32'(rdata);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_INS: begin
                // walk from the rear towards the insert point
                if (r_idx == pos_c) begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    raddr   = slot_of(r_front, r_idx - 1'b1);
                    n_state = S_INSWR;
                end
            end
            S_INSWR: begin
                we      = 1'b1;
                wdata   = rdata;
                n_idx   = r_idx - 1'b1;
                n_state = S_INS;
            end
            S_DEL: begin
                if (r_idx + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    raddr   = slot_of(r_front, r_idx + 1'b1);
                    n_state = S_DELWR;
                end
            end
            S_DELWR: begin
                we      = 1'b1;
                wdata   = rdata;
                n_idx   = r_idx + 1'b1;
                n_state = S_DEL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_idx    <= n_idx;
        r_pc     <= n_pc;
        r_rd     <= n_rd;
        r_status <= n_status;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_read_value     = r_rd;
    assign o_element_count  = 7'(r_count);
    assign o_status         = r_status;
    assign o_position_class = r_pc;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT) else $error("count beyond capacity");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(busy)) else $error("result without request");
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> r_count == CAP_CNT)
        else $error("full refusal with room left");
`endif
endmodule
